>>> design/assert_macros.svh
// assertion macros for the rtl of the mppt tracker
// no dependencies; clock aclk and reset aresetn are taken from the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define MPPT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// check that a condition in one cycle implies a result in the next
`define MPPT_ASSERT_NEXT(label, cond, res, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (res)) \
        else $error(msg);

`endif

>>> design/mppt_po_pkg.sv
// types and constants of the adaptive perturb-and-observe mppt tracker
// no dependencies; imported by the top level
package mppt_po_pkg;

    // field widths
    localparam int VOLT_W  = 16;
    localparam int CURR_W  = 16;
    localparam int TEMP_W  = 12;
    localparam int POWER_W = 32;
    localparam int DUTY_W  = 16;
    localparam int STEP_W  = 16;
    localparam int FAULT_W = 4;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 56;

    // configuration port
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_DUTY_MIN     = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DUTY_MAX     = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_MIN     = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_MAX     = 8'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_TEMP_LIMIT   = 8'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_BATT_LOW     = 8'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_BATT_HIGH    = 8'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_POWER_LIMIT  = 8'd7;

    // register reset values
    localparam logic [DUTY_W-1:0]        RST_DUTY_MIN    = 16'd3277;
    localparam logic [DUTY_W-1:0]        RST_DUTY_MAX    = 16'd62259;
    localparam logic [STEP_W-1:0]        RST_STEP_MIN    = 16'd1;
    localparam logic [STEP_W-1:0]        RST_STEP_MAX    = 16'd6554;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_LIMIT  = 12'sd750;
    localparam logic [VOLT_W-1:0]        RST_BATT_LOW    = 16'd10500;
    localparam logic [VOLT_W-1:0]        RST_BATT_HIGH   = 16'd14500;
    localparam logic [POWER_W-1:0]       RST_POWER_LIMIT = 32'd500000000;

    // tracker state reset: step of 0.01
    localparam logic [STEP_W-1:0] RST_STEP = 16'd655;

    // step scaling: (s * k + 5) / 10, divide by 10 as multiply by 2^23/10 rounded up
    localparam int                 SCALE_W     = 20;
    localparam logic [SCALE_W-1:0] GROW_MUL    = 20'd11;
    localparam logic [SCALE_W-1:0] SHRINK_MUL  = 20'd9;
    localparam logic [SCALE_W-1:0] ROUND_ADD   = 20'd5;
    localparam int                 RECIP_W     = 20;
    localparam logic [RECIP_W-1:0] RECIP_TEN   = 20'd838861;
    localparam int                 RECIP_SHIFT = 23;

    // fault bit positions
    localparam int FAULT_OVERTEMP  = 0;
    localparam int FAULT_BATT_LOW  = 1;
    localparam int FAULT_BATT_HIGH = 2;
    localparam int FAULT_OVERLOAD  = 3;

    // one input sample as packed in s_tdata, first field lowest
    typedef struct packed {
        logic [S_TDATA_W-VOLT_W-CURR_W-VOLT_W-TEMP_W-1:0] pad;
        logic signed [TEMP_W-1:0]                         temperature;
        logic [VOLT_W-1:0]                                battery_voltage;
        logic [CURR_W-1:0]                                panel_current;
        logic [VOLT_W-1:0]                                panel_voltage;
    } sample_t;

    // one result as packed in m_tdata, first field lowest
    typedef struct packed {
        logic [M_TDATA_W-DUTY_W-POWER_W-FAULT_W-2:0] pad;
        logic                                        pwm_enable;
        logic [FAULT_W-1:0]                          fault_flags;
        logic [POWER_W-1:0]                          panel_power;
        logic [DUTY_W-1:0]                           duty;
    } result_t;

endpackage

>>> design/mppt_adaptive_perturb_observe.sv
// adaptive perturb-and-observe mppt tracker with sticky faults and pwm latch-off
// depends on mppt_po_pkg and assert_macros.svh
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata: sample fields
//  m_      | out       | m_tvalid/m_tready  | m_tdata: result fields
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_addr, cfg_data
//
// one sample per cycle when not stalled; input register then result register
// the tracker loop (power compare, step scale, duty clamp) is combinational
// synchronous active-low reset restores config, valid flags and tracker state
// a stalled result holds the result register; one more sample may wait behind it
// configuration writes are accepted every cycle
`include "assert_macros.svh"

module mppt_adaptive_perturb_observe (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // sample stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // panel_voltage, panel_current, battery_voltage, temperature, zero pad
    input  logic [mppt_po_pkg::S_TDATA_W-1:0]    s_tdata,
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // duty, panel_power, fault_flags, pwm_enable, zero pad
    output logic [mppt_po_pkg::M_TDATA_W-1:0]    m_tdata,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mppt_po_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [mppt_po_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mppt_po_pkg::*;

    // configuration registers
    logic [DUTY_W-1:0]        duty_min_reg;
    logic [DUTY_W-1:0]        duty_max_reg;
    logic [STEP_W-1:0]        step_min_reg;
    logic [STEP_W-1:0]        step_max_reg;
    logic signed [TEMP_W-1:0] temp_limit_reg;
    logic [VOLT_W-1:0]        batt_low_reg;
    logic [VOLT_W-1:0]        batt_high_reg;
    logic [POWER_W-1:0]       power_limit_reg;

    // tracker state
    logic [POWER_W-1:0] last_power_reg,  last_power_next;
    logic [VOLT_W-1:0]  last_voltage_reg, last_voltage_next;
    logic [STEP_W-1:0]  step_size_reg,   step_size_next;
    logic [DUTY_W-1:0]  duty_value_reg,  duty_value_next;
    logic [FAULT_W-1:0] fault_bits_reg,  fault_bits_next;
    logic               pwm_allowed_reg, pwm_allowed_next;

    // pipeline registers
    logic    in_vld_reg;
    sample_t in_reg;
    logic    out_vld_reg;
    result_t out_reg, out_next;

    logic advance;
    logic load_in;

    // handshake: result register frees when taken, input register when it moves on
    assign advance   = !out_vld_reg || m_tready;
    assign s_tready  = !in_vld_reg || advance;
    assign load_in   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = out_reg;

    // configuration write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_min_reg    <= RST_DUTY_MIN;
            duty_max_reg    <= RST_DUTY_MAX;
            step_min_reg    <= RST_STEP_MIN;
            step_max_reg    <= RST_STEP_MAX;
            temp_limit_reg  <= RST_TEMP_LIMIT;
            batt_low_reg    <= RST_BATT_LOW;
            batt_high_reg   <= RST_BATT_HIGH;
            power_limit_reg <= RST_POWER_LIMIT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                CFG_DUTY_MIN:    duty_min_reg    <= cfg_data[DUTY_W-1:0];
                CFG_DUTY_MAX:    duty_max_reg    <= cfg_data[DUTY_W-1:0];
                CFG_STEP_MIN:    step_min_reg    <= cfg_data[STEP_W-1:0];
                CFG_STEP_MAX:    step_max_reg    <= cfg_data[STEP_W-1:0];
                CFG_TEMP_LIMIT:  temp_limit_reg  <= signed'(cfg_data[TEMP_W-1:0]);
                CFG_BATT_LOW:    batt_low_reg    <= cfg_data[VOLT_W-1:0];
                CFG_BATT_HIGH:   batt_high_reg   <= cfg_data[VOLT_W-1:0];
                CFG_POWER_LIMIT: power_limit_reg <= cfg_data[POWER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // tracker datapath
    logic [POWER_W-1:0]              power;
    logic                            p_up;
    logic                            v_up;
    logic                            grow;
    logic [SCALE_W-1:0]              grow_num;
    logic [SCALE_W-1:0]              shrink_num;
    logic [SCALE_W+RECIP_W-1:0]      grow_prod;
    logic [SCALE_W+RECIP_W-1:0]      shrink_prod;
    logic [STEP_W:0]                 step_scaled;
    logic [STEP_W:0]                 step_low_cl;
    logic signed [DUTY_W+1:0]        duty_sum;
    logic signed [DUTY_W+1:0]        duty_hi_cl;

    always_comb begin
        // panel power, exact 16x16 product
        power = 32'(in_reg.panel_voltage) * 32'(in_reg.panel_current);
        p_up  = power > last_power_reg;
        v_up  = in_reg.panel_voltage > last_voltage_reg;
        grow  = (p_up == v_up);

        // both step candidates from the current step, rounded half up
        grow_num    = SCALE_W'(step_size_reg) * GROW_MUL + ROUND_ADD;
        shrink_num  = SCALE_W'(step_size_reg) * SHRINK_MUL + ROUND_ADD;
        grow_prod   = (SCALE_W+RECIP_W)'(grow_num) * (SCALE_W+RECIP_W)'(RECIP_TEN);
        shrink_prod = (SCALE_W+RECIP_W)'(shrink_num) * (SCALE_W+RECIP_W)'(RECIP_TEN);
        step_scaled = grow ? grow_prod[RECIP_SHIFT +: STEP_W+1]
                           : shrink_prod[RECIP_SHIFT +: STEP_W+1];

        // step clamp, upper limit wins
        step_low_cl = (step_scaled < {1'b0, step_min_reg}) ? {1'b0, step_min_reg}
                                                            : step_scaled;
        step_size_next = (step_low_cl > {1'b0, step_max_reg}) ? step_max_reg
                                                               : step_low_cl[STEP_W-1:0];

        // duty move, then clamp with lower limit winning
        if (grow) begin
            duty_sum = signed'({2'b00, duty_value_reg}) + signed'({2'b00, step_size_next});
        end else begin
            duty_sum = signed'({2'b00, duty_value_reg}) - signed'({2'b00, step_size_next});
        end
        duty_hi_cl = (duty_sum > signed'({2'b00, duty_max_reg})) ?
                     signed'({2'b00, duty_max_reg}) : duty_sum;
        duty_value_next = (duty_hi_cl < signed'({2'b00, duty_min_reg})) ? duty_min_reg
                                                                   : duty_hi_cl[DUTY_W-1:0];

        last_power_next   = power;
        last_voltage_next = in_reg.panel_voltage;

        // sticky faults and pwm latch-off
        fault_bits_next  = fault_bits_reg;
        pwm_allowed_next = pwm_allowed_reg;
        if (in_reg.temperature > temp_limit_reg) begin
            fault_bits_next[FAULT_OVERTEMP] = 1'b1;
            pwm_allowed_next                = 1'b0;
        end
        if (in_reg.battery_voltage < batt_low_reg) begin
            fault_bits_next[FAULT_BATT_LOW] = 1'b1;
        end
        if (in_reg.battery_voltage > batt_high_reg) begin
            fault_bits_next[FAULT_BATT_HIGH] = 1'b1;
        end
        if (power > power_limit_reg) begin
            fault_bits_next[FAULT_OVERLOAD] = 1'b1;
            pwm_allowed_next                = 1'b0;
        end

        // result word
        out_next             = '0;
        out_next.duty        = duty_value_next;
        out_next.panel_power = power;
        out_next.fault_flags = fault_bits_next;
        out_next.pwm_enable  = pwm_allowed_next;
    end

    // control state and tracker state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
            last_power_reg  <= '0;
            last_voltage_reg <= '0;
            step_size_reg   <= RST_STEP;
            duty_value_reg  <= '0;
            fault_bits_reg  <= '0;
            pwm_allowed_reg <= 1'b1;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (advance) begin
                out_vld_reg <= in_vld_reg;
            end
            if (in_vld_reg && advance) begin
                last_power_reg   <= last_power_next;
                last_voltage_reg <= last_voltage_next;
                step_size_reg    <= step_size_next;
                duty_value_reg   <= duty_value_next;
                fault_bits_reg   <= fault_bits_next;
                pwm_allowed_reg  <= pwm_allowed_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (load_in) begin
            in_reg <= s_tdata;
        end
        if (in_vld_reg && advance) begin
            out_reg <= out_next;
        end
    end

    // pwm stays off once latched
    `MPPT_ASSERT_NEXT(a_pwm_latch, !pwm_allowed_reg, !pwm_allowed_reg,
        "pwm latch released without reset")
    // fault bits never clear outside reset
    `MPPT_ASSERT_NEXT(a_fault_sticky, 1'b1,
        (fault_bits_reg & $past(fault_bits_reg)) == $past(fault_bits_reg),
        "sticky fault bit cleared")
    // a result with pwm off carries a latching fault
    `MPPT_ASSERT(a_pwm_cause,
        m_tvalid && !out_reg.pwm_enable |->
            out_reg.fault_flags[FAULT_OVERTEMP] || out_reg.fault_flags[FAULT_OVERLOAD],
        "pwm off without overtemp or overload")
    // tracker state holds while the pipeline is stalled
    `MPPT_ASSERT_NEXT(a_state_hold, in_vld_reg && !advance,
        $stable(duty_value_reg) && $stable(step_size_reg),
        "tracker state moved during a stall")

endmodule
